[sv/hkv_pkg.sv]
// hkv_pkg: sizes, operation and status codes, control/status structs
// shared by the hashed key-value table controller, datapath and checker
// no dependencies
package hkv_pkg;

  // table geometry and field widths
  localparam int BUCKETS    = 64;
  localparam int WAYS       = 4;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int SLOTS      = BUCKETS * WAYS;

  localparam int CFG_BITS    = 7;
  localparam int MOD_RESET   = 61;
  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 9;

  localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

  // modulus path: wide enough for the clamped divisor
  localparam int MOD_W = (BUCKET_BITS + 1 > CFG_BITS) ? BUCKET_BITS + 1 : CFG_BITS;

  // key bits consumed per reduction cycle
  localparam int DIV_STEP     = 4;
  localparam int DIV_CYCLES   = (KEY_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int SHIFT_W      = DIV_CYCLES * DIV_STEP;
  localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // operation codes
  localparam logic [MODE_BITS-1:0] MODE_PUT    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_GET    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd2;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic load;      // capture input item, start reduction
    logic div_step;  // one reduction step
    logic read_en;   // read bucket row
    logic cmp_en;    // register way compare
    logic commit;    // write back and load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new result
  } dp_status_t;

endpackage

[sv/hashed_key_value_table_core.sv]
// hashed_key_value_table_core: top level of the hashed key-value table,
// joining hkv_ctrl and hkv_dp; depends on hkv_pkg
//
// Key-value store of 64 buckets by 4 ways. A key goes to bucket
// (key mod bucket_modulus), the modulus clamped into 2..64. Each input
// transfer is one put, get or remove; each gives exactly one result
// transfer with status, read value and the entry count after the operation.
// An item passes from its input transfer to its result being offered through
// the modulo reduction (a restoring divider taking 4 key bits a cycle), the
// bucket row read, the way compare and a last step that writes the row back
// and loads the result register. One item is in flight at a time and the
// next is taken in the idle state after the write back, so no new item is
// taken before the previous one has been written back. A new item is taken
// while the previous result still waits in the output register; its write
// back waits until that result has gone. Valid marks sit in flip-flops and
// are cleared by reset directly, so the table is usable from the first cycle
// after reset with no clearing pass. The modulus register may be written at
// any time the block is idle; cfg_ready is always high.
module hashed_key_value_table_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hkv_pkg::CFG_BITS-1:0]        cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hkv_pkg::MODE_BITS-1:0]       in_mode,
  input  logic [hkv_pkg::KEY_BITS-1:0]        in_key,
  input  logic [hkv_pkg::VALUE_BITS-1:0]      in_value,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hkv_pkg::STATUS_BITS-1:0]     out_status,
  output logic [hkv_pkg::VALUE_BITS-1:0]      out_read_value,
  output logic [hkv_pkg::COUNT_BITS-1:0]      out_entry_count
);
  import hkv_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer: idle, reduction, row read, compare, commit
  hkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (dp_status)
  );

  // datapath: modulus register, divider, row memories, result register
  hkv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (dp_status),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .cfg_ready       (cfg_ready),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

endmodule

[sv/hkv_ctrl.sv]
// hkv_ctrl: sequencing state machine for the hashed key-value table
// depends on hkv_pkg
module hkv_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  output hkv_pkg::ctrl_cmd_t     cmd,
  input  hkv_pkg::dp_status_t    status
);
  import hkv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_CMP,
    S_COMMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(DIV_CYCLES - 1)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[sv/hkv_dp.sv]
// hkv_dp: modulo reduction, bucket row memories, way compare, write back
// and result register of the hashed key-value table; depends on hkv_pkg
module hkv_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hkv_pkg::ctrl_cmd_t                  cmd,
  output hkv_pkg::dp_status_t                 status,
  input  logic                                cfg_valid,
  input  logic [hkv_pkg::CFG_BITS-1:0]        cfg_data,
  output logic                                cfg_ready,
  input  logic [hkv_pkg::MODE_BITS-1:0]       in_mode,
  input  logic [hkv_pkg::KEY_BITS-1:0]        in_key,
  input  logic [hkv_pkg::VALUE_BITS-1:0]      in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hkv_pkg::STATUS_BITS-1:0]     out_status,
  output logic [hkv_pkg::VALUE_BITS-1:0]      out_read_value,
  output logic [hkv_pkg::COUNT_BITS-1:0]      out_entry_count
);
  import hkv_pkg::*;

  logic [CFG_BITS-1:0]    mod_r;
  logic [MOD_W-1:0]       mod_ext, eff_mod, eff_mod_r;
  logic [MODE_BITS-1:0]   mode_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [VALUE_BITS-1:0]  val_r;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [MOD_W-1:0]       rem_r, rem_nxt;
  logic [BUCKET_BITS-1:0] bucket;

  logic [WAYS-1:0][KEY_BITS-1:0]   key_mem [BUCKETS];
  logic [WAYS-1:0][VALUE_BITS-1:0] val_mem [BUCKETS];
  logic [WAYS-1:0]                 valid_r [BUCKETS];

  logic [WAYS-1:0][KEY_BITS-1:0]   key_row_r, key_row_wr;
  logic [WAYS-1:0][VALUE_BITS-1:0] val_row_r, val_row_wr;
  logic [WAYS-1:0]                 vrow_r;

  logic                hit_nxt, hit_r, free_nxt, free_r;
  logic [WAY_BITS-1:0] hit_way_nxt, hit_way_r, free_way_nxt, free_way_r, way_sel;

  logic                   key_we, val_we, set_valid, clr_valid;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [STATUS_BITS-1:0] status_nxt, out_status_r;
  logic [VALUE_BITS-1:0]  rd_nxt, out_read_value_r;
  logic [COUNT_BITS-1:0]  out_entry_count_r;
  logic                   out_valid_r, out_valid_nxt;

  // divisor clamped into 2..BUCKETS
  always_comb begin
    mod_ext = MOD_W'(mod_r);
    if (mod_ext < MOD_W'(2)) begin
      eff_mod = MOD_W'(2);
    end else if (mod_ext > MOD_W'(BUCKETS)) begin
      eff_mod = MOD_W'(BUCKETS);
    end else begin
      eff_mod = mod_ext;
    end
  end

  // restoring reduction, DIV_STEP key bits per cycle, msb first
  always_comb begin
    logic [MOD_W-1:0] r;
    logic [MOD_W:0]   t;
    r = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, shift_r[SHIFT_W-1-i]};
      if (t >= {1'b0, eff_mod_r}) begin
        t = t - {1'b0, eff_mod_r};
      end
      r = t[MOD_W-1:0];
    end
    rem_nxt   = r;
    shift_nxt = shift_r << DIV_STEP;
  end

  assign bucket = rem_r[BUCKET_BITS-1:0];

  // way compare, lowest way wins
  always_comb begin
    hit_nxt      = 1'b0;
    hit_way_nxt  = '0;
    free_nxt     = 1'b0;
    free_way_nxt = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow_r[w] && (key_row_r[w] == key_r)) begin
        hit_nxt     = 1'b1;
        hit_way_nxt = WAY_BITS'(w);
      end
      if (!vrow_r[w]) begin
        free_nxt     = 1'b1;
        free_way_nxt = WAY_BITS'(w);
      end
    end
  end

  // operation decision
  always_comb begin
    key_we     = 1'b0;
    val_we     = 1'b0;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_nxt     = '0;
    way_sel    = hit_r ? hit_way_r : free_way_r;
    case (mode_r) inside
      MODE_PUT: begin
        if (hit_r) begin
          val_we = 1'b1;
        end else if (free_r) begin
          key_we    = 1'b1;
          val_we    = 1'b1;
          set_valid = 1'b1;
          count_nxt = count_r + COUNT_BITS'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      MODE_GET, MODE_REMOVE: begin
        if (hit_r) begin
          rd_nxt = val_row_r[hit_way_r];
          if (mode_r == MODE_REMOVE) begin
            clr_valid = 1'b1;
            count_nxt = count_r - COUNT_BITS'(1);
          end
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    key_row_wr          = key_row_r;
    key_row_wr[way_sel] = key_r;
    val_row_wr          = val_row_r;
    val_row_wr[way_sel] = val_r;
  end

  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt   = cmd.commit || (out_valid_r && out_stall);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= CFG_BITS'(MOD_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < BUCKETS; b++) begin
        valid_r[b] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        mod_r <= cfg_data;
      end
      out_valid_r <= out_valid_nxt;
      if (cmd.commit) begin
        count_r <= count_nxt;
        if (set_valid) begin
          valid_r[bucket][way_sel] <= 1'b1;
        end else if (clr_valid) begin
          valid_r[bucket][way_sel] <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      key_r     <= in_key;
      val_r     <= in_value;
      shift_r   <= SHIFT_W'(in_key);
      rem_r     <= '0;
      eff_mod_r <= eff_mod;
    end else if (cmd.div_step) begin
      shift_r <= shift_nxt;
      rem_r   <= rem_nxt;
    end
    if (cmd.read_en) begin
      vrow_r <= valid_r[bucket];
    end
    if (cmd.cmp_en) begin
      hit_r      <= hit_nxt;
      hit_way_r  <= hit_way_nxt;
      free_r     <= free_nxt;
      free_way_r <= free_way_nxt;
    end
    if (cmd.commit) begin
      out_status_r      <= status_nxt;
      out_read_value_r  <= rd_nxt;
      out_entry_count_r <= count_nxt;
    end
  end

  // bucket key rows
  always_ff @(posedge clk) begin
    if (cmd.commit && key_we) begin
      key_mem[bucket] <= key_row_wr;
    end
    if (cmd.read_en) begin
      key_row_r <= key_mem[bucket];
    end
  end

  // bucket value rows
  always_ff @(posedge clk) begin
    if (cmd.commit && val_we) begin
      val_mem[bucket] <= val_row_wr;
    end
    if (cmd.read_en) begin
      val_row_r <= val_mem[bucket];
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

endmodule

[sv/hkv_checker.sv]
// hkv_checker: port-level assertions for hashed_key_value_table_core
// and the bind that attaches them; depends on hkv_pkg
module hkv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [hkv_pkg::STATUS_BITS-1:0]     out_status,
  input logic [hkv_pkg::VALUE_BITS-1:0]      out_read_value,
  input logic [hkv_pkg::COUNT_BITS-1:0]      out_entry_count
);
  import hkv_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_entry_count))
    else $error("stalled result changed");

  // one item in flight: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // miss or full gives zero read value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_read_value == '0)
    else $error("nonzero read value on a failed operation");

  // count never beyond table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= COUNT_BITS'(SLOTS))
    else $error("entry count above table size");

  // a full bucket implies at least one bucket's worth of entries
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_count >= COUNT_BITS'(WAYS))
    else $error("bucket full reported with too few entries");

endmodule

bind hashed_key_value_table_core hkv_checker u_hkv_checker (.*);

[sim/hkv_table_checker.sv]
`timescale 1ns / 1ps
// hkv_table_checker: watches the configuration, input and result channels of
// the hashed key-value table, predicts every result and compares; uses hkv_pkg
module hkv_table_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [hkv_pkg::CFG_BITS-1:0]       cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [hkv_pkg::MODE_BITS-1:0]      in_mode,
  input  logic [hkv_pkg::KEY_BITS-1:0]       in_key,
  input  logic [hkv_pkg::VALUE_BITS-1:0]     in_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [hkv_pkg::STATUS_BITS-1:0]    out_status,
  input  logic [hkv_pkg::VALUE_BITS-1:0]     out_read_value,
  input  logic [hkv_pkg::COUNT_BITS-1:0]     out_entry_count,
  output int                                 fail_count,
  output int                                 pending
);
  import hkv_pkg::*;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [VALUE_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0]  entry_count;
  } table_result_t;

  // shadow copy of the table contents
  logic                  slot_used [SLOTS];
  logic [KEY_BITS-1:0]   slot_key  [SLOTS];
  logic [VALUE_BITS-1:0] slot_val  [SLOTS];
  logic [COUNT_BITS-1:0] stored;
  logic [CFG_BITS-1:0]   modulus;

  table_result_t result_q[$];
  int            mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic table_result_t apply_op(input logic [MODE_BITS-1:0]  mode,
                                             input logic [KEY_BITS-1:0]   key,
                                             input logic [VALUE_BITS-1:0] value);
    int            m;
    int            base;
    int            hit;
    int            free_way;
    table_result_t r;
    m = int'(modulus);
    if (m < 2) m = 2;
    if (m > BUCKETS) m = BUCKETS;
    base     = int'(key % 32'(m)) * WAYS;
    hit      = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_used[base + w]) begin
        if (hit < 0 && slot_key[base + w] == key) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    r = '0;
    r.status = ST_OK;
    case (mode)
      MODE_PUT: begin
        if (hit >= 0) begin
          slot_val[base + hit] = value;
        end else if (free_way >= 0) begin
          slot_used[base + free_way] = 1'b1;
          slot_key[base + free_way]  = key;
          slot_val[base + free_way]  = value;
          stored = stored + COUNT_BITS'(1);
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_GET, MODE_REMOVE: begin
        if (hit >= 0) begin
          r.read_value = slot_val[base + hit];
          if (mode == MODE_REMOVE) begin
            slot_used[base + hit] = 1'b0;
            stored = stored - COUNT_BITS'(1);
          end
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.entry_count = stored;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    table_result_t got;
    table_result_t want;
    if (!rst_n) begin
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      stored  = '0;
      modulus = CFG_BITS'(MOD_RESET);
      result_q.delete();
    end else begin
      // result side first: nothing taken at this edge can already be out
      if (out_valid && !out_stall) begin
        got = '{out_status, out_read_value, out_entry_count};
        if (result_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing expected: status %0d value %h count %0d",
                     $realtime, got.status, got.read_value, got.entry_count);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (got.status !== want.status || got.read_value !== want.read_value ||
              got.entry_count !== want.entry_count) begin
            if (mismatches < 10)
              $display("%0t: mismatch: status %0d/%0d value %h/%h count %0d/%0d (exp/got)",
                       $realtime, want.status, got.status, want.read_value,
                       got.read_value, want.entry_count, got.entry_count);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) modulus = cfg_data;
      if (in_valid && !in_stall) result_q.push_back(apply_op(in_mode, in_key, in_value));
    end
    fail_count <= mismatches;
    pending    <= result_q.size();
  end

endmodule

[sim/tb_hashed_key_value_table_core.sv]
`timescale 1ns / 1ps
// tb_hashed_key_value_table_core: stimulus and verdict for the hashed key-value
// table; depends on hkv_pkg, hashed_key_value_table_core and hkv_table_checker
module tb_hashed_key_value_table_core;
  import hkv_pkg::*;

  // unused operation code, must behave as a no-op
  localparam logic [MODE_BITS-1:0] MODE_NOP = 2'd3;

  localparam int RUN_LIMIT    = 1000000;  // cycle limit for the watchdog
  localparam int HOLD_CYCLES  = 300;      // long receiver hold-off
  localparam int POOL_KEYS    = 24;       // colliding keys per phase, 8 per bucket
  localparam int PHASE_ITEMS  = 110;
  localparam int LAST_ITEMS   = 160;
  localparam int DRAIN_CYCLES = 30;       // extra wait after the checker has drained

  logic clk = 1'b0;
  logic rst_n;

  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_BITS-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [MODE_BITS-1:0]   in_mode;
  logic [KEY_BITS-1:0]    in_key;
  logic [VALUE_BITS-1:0]  in_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_BITS-1:0] out_status;
  logic [VALUE_BITS-1:0]  out_read_value;
  logic [COUNT_BITS-1:0]  out_entry_count;

  int fail_count;
  int pending;

  // idle bursts on both sides while set; hold_req asks the receiver for a long stall
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hashed_key_value_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

  hkv_table_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // one operation offered at a falling edge, held until the rising edge that
  // takes it; valid is left high so back-to-back transfers need no toggling
  task automatic push_op(input logic [MODE_BITS-1:0]  mode,
                         input logic [KEY_BITS-1:0]   key,
                         input logic [VALUE_BITS-1:0] value);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // new colliding key set: three buckets under the effective modulus, eight
  // keys each, so buckets run full and chains get searched past the first way
  task automatic refresh_pool(input logic [CFG_BITS-1:0] m);
    int     eff;
    int     b;
    longint top_q;
    longint q;
    eff = int'(m);
    if (eff < 2) eff = 2;
    if (eff > BUCKETS) eff = BUCKETS;
    b = 0;
    for (int i = 0; i < POOL_KEYS; i++) begin
      if (i % 8 == 0) b = $urandom_range(0, eff - 1);
      top_q = (64'hFFFF_FFFF - b) / eff;
      q = $urandom_range(0, 32'(top_q));
      key_pool[i] = KEY_BITS'(q * eff + b);
    end
  endtask

  // modulus written only once the table has drained
  task automatic write_modulus(input logic [CFG_BITS-1:0] m);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    refresh_pool(m);
  endtask

  // weighted towards put so buckets fill, with enough removes to free ways
  task automatic random_op();
    int                    pick;
    logic [MODE_BITS-1:0]  mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    pick = $urandom_range(0, 99);
    if (pick < 40)      mode = MODE_PUT;
    else if (pick < 70) mode = MODE_GET;
    else if (pick < 95) mode = MODE_REMOVE;
    else                mode = MODE_NOP;
    if ($urandom_range(0, 4) == 0) key = $urandom();
    else key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    pick = $urandom_range(0, 15);
    if (pick == 0)      value = '0;
    else if (pick == 1) value = '1;
    else                value = $urandom();
    push_op(mode, key, value);
  endtask

  // receiver: random stall bursts, or one long hold-off when asked
  initial begin : receiver
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle counter guarding against a hung block
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_BITS-1:0] moduli [11];
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_mode   = MODE_PUT;
    in_key    = '0;
    in_value  = '0;
    moduli    = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd5, 7'd127, 7'd65, 7'd13, 7'd31, 7'd47, 7'd0};
    moduli[10] = CFG_BITS'($urandom_range(0, 127));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, under the reset modulus of 61: bucket 0 holds 0, 61, 122, 183
    push_op(MODE_GET, 32'd5, 32'h0);                 // empty table
    push_op(MODE_REMOVE, 32'd5, 32'h0);
    push_op(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unused code, no effect
    push_op(MODE_PUT, 32'd0, 32'h0);
    push_op(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(MODE_GET, 32'hFFFF_FFFF, 32'h0);
    push_op(MODE_GET, 32'd0, 32'h1234_5678);         // value ignored on get
    push_op(MODE_PUT, 32'd61, 32'hA5A5_A5A5);
    push_op(MODE_PUT, 32'd122, 32'h5A5A_5A5A);
    push_op(MODE_PUT, 32'd183, 32'h0F0F_F0F0);
    push_op(MODE_PUT, 32'd244, 32'hDEAD_0001);       // bucket full
    push_op(MODE_PUT, 32'd122, 32'hC0DE_0002);       // update inside a full bucket
    push_op(MODE_GET, 32'd122, 32'h0);
    push_op(MODE_REMOVE, 32'd61, 32'h0);
    push_op(MODE_GET, 32'd61, 32'h0);
    push_op(MODE_REMOVE, 32'd61, 32'h0);             // already gone
    push_op(MODE_PUT, 32'd244, 32'hDEAD_0003);       // takes the freed way
    push_op(MODE_GET, 32'd244, 32'h0);
    push_op(MODE_GET, 32'd305, 32'h0);               // same bucket, key not stored
    push_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
    push_op(MODE_NOP, 32'd0, 32'h0);
    push_op(MODE_GET, 32'h8000_0000, 32'h0);

    // fill every slot at modulus 64 so the count reaches its top, with the
    // receiver holding off at the start so the input side backs up
    write_modulus(7'd64);
    hold_req = 1'b1;
    for (int i = 0; i < 320; i++) push_op(MODE_PUT, KEY_BITS'(i), $urandom());
    for (int i = 0; i < 320; i++) push_op(MODE_REMOVE, KEY_BITS'(i), $urandom());

    // random phases across the modulus range, clamped ends included
    for (int ph = 0; ph < 11; ph++) begin
      write_modulus(moduli[ph]);
      idle_on = (ph % 4 != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) random_op();
    end

    // last stretch at full rate, no idling on either side
    write_modulus(7'd61);
    idle_on = 1'b0;
    for (int i = 0; i < LAST_ITEMS; i++) random_op();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/hkv_pkg.sv
sv/hkv_ctrl.sv
sv/hkv_dp.sv
sv/hashed_key_value_table_core.sv
sv/hkv_checker.sv
sim/hkv_table_checker.sv
sim/tb_hashed_key_value_table_core.sv
